// File: src/policy_dominance_result_cache_macros.svh
// Assertion macros for the policy dominance result cache.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef POLICY_DOMINANCE_RESULT_CACHE_MACROS_SVH
`define POLICY_DOMINANCE_RESULT_CACHE_MACROS_SVH

// cond holds at every clock edge out of reset
`define PDRC_CHECK(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define PDRC_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/pdrc_pkg.sv
// Shared types and constants for the policy dominance result cache.
// No dependencies.
package pdrc_pkg;

    localparam int KEY_W        = 198;
    localparam int POL_FIELD_W  = 8;
    localparam int PAY_FIELD_W  = 64;
    localparam int S_TDATA_W    = 272;
    localparam int M_TDATA_W    = 80;
    localparam int RES_W        = 74;

    localparam int TABLE_SLOTS_DEF  = 64;
    localparam int POLICY_BITS_DEF  = 8;
    localparam int PAYLOAD_BITS_DEF = 64;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // request broadcast to every cell
    typedef struct packed {
        logic                   cmd;
        logic [KEY_W-1:0]       key;
        logic [POL_FIELD_W-1:0] pol;
        logic [PAY_FIELD_W-1:0] pay;
    } req_t;

    // token and running result passed cell to cell
    typedef struct packed {
        logic                   tok;
        logic                   done;
        logic                   have;
        logic [POL_FIELD_W-1:0] best_pol;
        logic [PAY_FIELD_W-1:0] best_pay;
    } carry_t;

endpackage

// File: src/pdrc_cell.sv
// One table slot of the result cache chain: stores an entry and
// advances the scan token. Depends on pdrc_pkg.
module pdrc_cell #(
    parameter int POL_W = pdrc_pkg::POLICY_BITS_DEF,
    parameter int PAY_W = pdrc_pkg::PAYLOAD_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  pdrc_pkg::req_t   req,
    input  pdrc_pkg::carry_t carry_in,
    output pdrc_pkg::carry_t carry_out,
    output logic             slot_valid
);

    localparam int PFW = pdrc_pkg::POL_FIELD_W;
    localparam int YFW = pdrc_pkg::PAY_FIELD_W;

    logic                          valid_reg;
    logic                          valid_next;
    logic [pdrc_pkg::KEY_W-1:0]    key_reg;
    logic [POL_W-1:0]              pol_reg;
    logic [PAY_W-1:0]              pay_reg;
    pdrc_pkg::carry_t              carry_reg;
    pdrc_pkg::carry_t              carry_next;

    logic           key_hit;
    logic           usable;
    logic           take;
    logic           is_upd;
    logic           wr_pay;
    logic           wr_new;
    logic [PFW-1:0] pol_ext;

    always_comb begin
        pol_ext = PFW'(pol_reg);
        key_hit = valid_reg && (key_reg == req.key);
        is_upd  = (req.cmd == pdrc_pkg::CMD_UPDATE);
        usable  = key_hit && ((pol_ext & ~req.pol) == '0);
        take    = carry_in.tok && !is_upd && usable &&
                  (!carry_in.have || ((carry_in.best_pol & ~pol_ext) == '0));
        wr_pay  = carry_in.tok && is_upd && !carry_in.done && key_hit &&
                  (pol_ext == req.pol);
        wr_new  = carry_in.tok && is_upd && !carry_in.done && !valid_reg;
        valid_next = valid_reg | wr_new;

        carry_next      = carry_in;
        carry_next.done = carry_in.done | wr_pay | wr_new;
        if (take) begin
            carry_next.have     = 1'b1;
            carry_next.best_pol = pol_ext;
            carry_next.best_pay = YFW'(pay_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            carry_reg.tok <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_new) begin
            key_reg <= req.key;
            pol_reg <= req.pol[POL_W-1:0];
        end
        if (wr_new || wr_pay) begin
            pay_reg <= req.pay[PAY_W-1:0];
        end
    end

    assign carry_out  = carry_reg;
    assign slot_valid = valid_reg;

endmodule

// File: src/policy_dominance_result_cache.sv
// Policy dominance result cache: a chain of TABLE_SLOTS cells, each
// holding one entry, scanned by a token that moves one cell per cycle.
// Request in on s_axis (tuser = command), result out on m_axis.
// Request tdata, low bit up: transform_kind[2:0], precision_mode[4:3],
//   length, in_stride, out_stride, batch_count, in_distance, out_distance
//   (32 bits each from bit 5), direction[197], policy_mask[205:198],
//   payload_in[269:206], zero pad to 272.
// Result tdata: found[0], found_policy[8:1], found_payload[72:9],
//   table_full[73], zero pad to 80.
// The scan token walks the cell chain from request to result; one request
// is in flight at a time, so a new one is taken only after the last
// result has moved into the output register.
// s_axis_tready is high only while the chain is empty.
// Reset clears all valid marks, so the table starts empty.
// A stalled result holds in the output register; a finished scan waits
// in res_reg (ST_DONE) until m_axis_tready frees the output register.
`include "policy_dominance_result_cache_macros.svh"

module policy_dominance_result_cache #(
    parameter int TABLE_SLOTS  = pdrc_pkg::TABLE_SLOTS_DEF,
    parameter int POLICY_BITS  = pdrc_pkg::POLICY_BITS_DEF,
    parameter int PAYLOAD_BITS = pdrc_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // kind, precision, length, in_stride, out_stride, batch, in_dist,
    // out_dist, direction, policy, payload
    input  logic [pdrc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // found, found_policy, found_payload, table_full
    output logic [pdrc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int PFW   = pdrc_pkg::POL_FIELD_W;
    localparam int YFW   = pdrc_pkg::PAY_FIELD_W;
    localparam int KW    = pdrc_pkg::KEY_W;
    localparam int POL_W = (POLICY_BITS < PFW) ? POLICY_BITS : PFW;
    localparam int PAY_W = PAYLOAD_BITS;
    localparam int RW    = pdrc_pkg::RES_W;
    localparam int MW    = pdrc_pkg::M_TDATA_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic              start_reg;
    logic              start_next;
    pdrc_pkg::req_t    req_reg;
    pdrc_pkg::req_t    req_next;
    logic [RW-1:0]     res_reg;
    logic [RW-1:0]     res_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [MW-1:0]     m_data_reg;
    logic [MW-1:0]     m_data_next;

    pdrc_pkg::carry_t        chain [TABLE_SLOTS+1];
    pdrc_pkg::carry_t        tail;
    logic [TABLE_SLOTS-1:0]  valid_vec;
    logic [TABLE_SLOTS-1:0]  valid_inc;
    logic [TABLE_SLOTS:0]    tok_vec;
    logic                    accept;
    logic                    full_flag;

    assign chain[0] = '{tok: start_reg, done: 1'b0, have: 1'b0,
                        best_pol: '0, best_pay: '0};

    for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
        pdrc_cell #(
            .POL_W (POL_W),
            .PAY_W (PAY_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .req        (req_reg),
            .carry_in   (chain[i]),
            .carry_out  (chain[i+1]),
            .slot_valid (valid_vec[i])
        );
        assign tok_vec[i+1] = chain[i+1].tok;
    end

    assign tok_vec[0] = start_reg;
    assign tail       = chain[TABLE_SLOTS];
    assign valid_inc  = valid_vec + TABLE_SLOTS'(1);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        req_next.cmd = s_axis_tuser[0];
        req_next.key = s_axis_tdata[KW-1:0];
        req_next.pol = PFW'(s_axis_tdata[KW +: POL_W]);
        req_next.pay = YFW'(s_axis_tdata[KW+PFW +: PAY_W]);

        full_flag  = (req_reg.cmd == pdrc_pkg::CMD_UPDATE) && !tail.done;
        res_next   = res_reg;
        state_next = state_reg;
        start_next = 1'b0;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    start_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tail.tok) begin
                    res_next   = {full_flag, tail.best_pay, tail.best_pol, tail.have};
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = MW'(res_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= req_next;
        end
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    `PDRC_CHECK(a_single_token, $onehot0(tok_vec), "more than one scan token in chain")
    `PDRC_IMPLY(a_ready_chain_empty, s_axis_tready, tok_vec == '0, "request taken during scan")
    `PDRC_CHECK(a_valid_prefix, (valid_inc & valid_vec) == '0, "valid slots not contiguous")
    `PDRC_IMPLY(a_tail_in_scan, tail.tok, state_reg == ST_SCAN, "scan ended outside scan state")

endmodule
